// ===== hdl/jsu_pkg.sv =====
package jsu_pkg;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic [20:0] CP_REPL = 21'h00FFFD;
	localparam logic [20:0] CP_SUPP = 21'h010000;

	// upper six bits of a UTF-16 unit that mark a surrogate half
	localparam logic [5:0] SURR_HIGH = 6'b110110;
	localparam logic [5:0] SURR_LOW  = 6'b110111;

	typedef enum logic [2:0] {
		M_WAIT,
		M_STR,
		M_ESC,
		M_HEX,
		M_PEND,
		M_PEND_ESC,
		M_PEND_HEX,
		M_DRAIN
	} mode_t;

	typedef enum logic [1:0] {
		ST_NONE,
		ST_DONE,
		ST_BAD
	} status_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_DONE = 2'd1,
		KIND_BAD  = 2'd2
	} kind_t;

	// All results of one input byte, in output order:
	// optional U+FFFD, optional raw byte or code point, optional status.
	typedef struct packed {
		logic        repl;
		logic        c2_v;
		logic        c2_raw;
		logic [20:0] c2_val;
		status_t     st;
	} entry_t;

endpackage

// ===== hdl/jsu_front.sv =====
module jsu_front import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_eoi,
	input  logic       q_ready,
	output logic       push,
	output entry_t     push_entry
);

	mode_t       mode_q, mode_d;
	logic [1:0]  digits_q, digits_d;
	logic [15:0] acc_q, acc_d;
	logic [9:0]  high_q, high_d;

	logic        accept;
	logic [4:0]  hex;
	logic [15:0] acc_new;
	entry_t      ent;

	// plain string byte
	mode_t       sb_mode;
	logic        sb_raw;
	status_t     sb_st;
	// escape letter
	mode_t       el_mode;
	logic        el_raw;
	logic [7:0]  el_val;
	status_t     el_st;
	// complete \u unit
	logic        fu_high;
	logic [20:0] fu_cp;

	function automatic logic [4:0] hex_of(input logic [7:0] b);
		logic [7:0] t;
		begin
			t = 8'h00;
			hex_of = 5'h00;
			if (b inside {[8'h30:8'h39]}) begin
				t = b - 8'h30;
				hex_of = {1'b1, t[3:0]};
			end else if (b inside {[8'h61:8'h66]}) begin
				t = b - 8'h57;
				hex_of = {1'b1, t[3:0]};
			end else if (b inside {[8'h41:8'h46]}) begin
				t = b - 8'h37;
				hex_of = {1'b1, t[3:0]};
			end
		end
	endfunction

	assign in_ready = q_ready;
	assign accept   = in_valid && q_ready;
	assign hex      = hex_of(in_byte);
	assign acc_new  = {acc_q[11:0], hex[3:0]};

	always_comb begin
		sb_mode = M_STR;
		sb_raw  = 1'b0;
		sb_st   = ST_NONE;
		if (in_byte == CH_QUOTE) begin
			sb_st   = ST_DONE;
			sb_mode = M_WAIT;
		end else if (in_byte < CH_SPACE) begin
			sb_st   = ST_BAD;
			sb_mode = M_DRAIN;
		end else if (in_byte == CH_BSLASH) begin
			sb_mode = M_ESC;
		end else begin
			sb_raw = 1'b1;
		end
	end

	always_comb begin
		el_mode = M_STR;
		el_raw  = 1'b1;
		el_val  = in_byte;
		el_st   = ST_NONE;
		case (in_byte)
			CH_QUOTE, CH_BSLASH, CH_SLASH: el_val = in_byte;
			8'h62: el_val = 8'h08;
			8'h66: el_val = 8'h0C;
			8'h6E: el_val = 8'h0A;
			8'h72: el_val = 8'h0D;
			8'h74: el_val = 8'h09;
			CH_U: begin
				el_raw  = 1'b0;
				el_mode = M_HEX;
			end
			default: begin
				el_raw  = 1'b0;
				el_st   = ST_BAD;
				el_mode = M_DRAIN;
			end
		endcase
	end

	assign fu_high = acc_new[15:10] == SURR_HIGH;
	assign fu_cp   = (acc_new[15:10] == SURR_LOW) ? CP_REPL : {5'd0, acc_new};

	always_comb begin
		mode_d   = mode_q;
		digits_d = digits_q;
		acc_d    = acc_q;
		high_d   = high_q;
		ent      = '{repl: 1'b0, c2_v: 1'b0, c2_raw: 1'b0, c2_val: 21'd0, st: ST_NONE};
		case (mode_q)
			M_WAIT: begin
				if (in_byte == CH_QUOTE) begin
					mode_d = M_STR;
				end else begin
					ent.st = ST_BAD;
					mode_d = M_DRAIN;
				end
			end
			M_STR, M_PEND: begin
				if (mode_q == M_PEND && in_byte == CH_BSLASH) begin
					mode_d = M_PEND_ESC;
				end else begin
					ent.repl   = mode_q == M_PEND;
					ent.c2_v   = sb_raw;
					ent.c2_raw = 1'b1;
					ent.c2_val = {13'd0, in_byte};
					ent.st     = sb_st;
					mode_d     = sb_mode;
				end
			end
			M_ESC, M_PEND_ESC: begin
				if (mode_q == M_PEND_ESC && in_byte == CH_U) begin
					mode_d   = M_PEND_HEX;
					digits_d = 2'd0;
					acc_d    = 16'd0;
				end else begin
					ent.repl   = mode_q == M_PEND_ESC;
					ent.c2_v   = el_raw;
					ent.c2_raw = 1'b1;
					ent.c2_val = {13'd0, el_val};
					ent.st     = el_st;
					mode_d     = el_mode;
					digits_d   = 2'd0;
					acc_d      = 16'd0;
				end
			end
			M_HEX, M_PEND_HEX: begin
				if (!hex[4]) begin
					ent.repl = mode_q == M_PEND_HEX;
					ent.st   = ST_BAD;
					mode_d   = M_DRAIN;
				end else begin
					acc_d = acc_new;
					if (digits_q != 2'd3) begin
						digits_d = digits_q + 2'd1;
					end else if (mode_q == M_PEND_HEX && acc_new[15:10] == SURR_LOW) begin
						// pair the low half with the held high half
						ent.c2_v   = 1'b1;
						ent.c2_val = CP_SUPP + {1'b0, high_q, acc_new[9:0]};
						mode_d     = M_STR;
					end else begin
						ent.repl = mode_q == M_PEND_HEX;
						if (fu_high) begin
							high_d = acc_new[9:0];
							mode_d = M_PEND;
						end else begin
							ent.c2_v   = 1'b1;
							ent.c2_val = fu_cp;
							mode_d     = M_STR;
						end
					end
				end
			end
			default: ;
		endcase

		if (in_eoi) begin
			if (mode_d inside {M_PEND, M_PEND_ESC, M_PEND_HEX}) begin
				ent.c2_v   = 1'b1;
				ent.c2_raw = 1'b0;
				ent.c2_val = CP_REPL;
				ent.st     = ST_BAD;
			end else if (mode_d != M_WAIT && mode_d != M_DRAIN) begin
				ent.st = ST_BAD;
			end
			mode_d = M_WAIT;
		end
	end

	// drop words that cause no result
	assign push       = accept && (ent.repl || ent.c2_v || ent.st != ST_NONE);
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_WAIT;
			digits_q <= 2'd0;
			acc_q    <= 16'd0;
			high_q   <= 10'd0;
		end else if (accept) begin
			mode_q   <= mode_d;
			digits_q <= digits_d;
			acc_q    <= acc_d;
			high_q   <= high_d;
		end
	end

endmodule

// ===== hdl/jsu_queue.sv =====
module jsu_queue import jsu_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   push_ready,
	input  logic   pop,
	output entry_t pop_entry,
	output logic   pop_valid
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push, do_pop;

	assign push_ready = cnt_q != CNT_W'(DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_entry  = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== hdl/jsu_back.sv =====
module jsu_back import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  entry_t     q_entry,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] out_kind,
	output logic       out_last
);

	logic        repl_q, c2v_q, c2raw_q;
	logic [20:0] c2val_q;
	status_t     st_q;
	logic [1:0]  idx_q;

	logic        repl_n, c2v_n;
	status_t     st_n;
	logic [1:0]  idx_n;

	logic        out_valid_q;
	logic [7:0]  byte_q;
	kind_t       kind_q;
	logic        last_q;

	logic        cur_any, out_free, emit, rest_any;
	logic [7:0]  byte_d;
	kind_t       kind_d;

	// index of the last UTF-8 byte of a code point
	function automatic logic [1:0] utf8_last(input logic [20:0] cp);
		if (cp <= 21'h7F)        utf8_last = 2'd0;
		else if (cp <= 21'h7FF)  utf8_last = 2'd1;
		else if (cp <= 21'hFFFF) utf8_last = 2'd2;
		else                     utf8_last = 2'd3;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
		logic [1:0] n;
		begin
			n = utf8_last(cp);
			utf8_byte = cp[7:0];
			case (n)
				2'd1: utf8_byte = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
				2'd2: begin
					case (idx)
						2'd0:    utf8_byte = {4'b1110, cp[15:12]};
						2'd1:    utf8_byte = {2'b10, cp[11:6]};
						default: utf8_byte = {2'b10, cp[5:0]};
					endcase
				end
				2'd3: begin
					case (idx)
						2'd0:    utf8_byte = {5'b11110, cp[20:18]};
						2'd1:    utf8_byte = {2'b10, cp[17:12]};
						2'd2:    utf8_byte = {2'b10, cp[11:6]};
						default: utf8_byte = {2'b10, cp[5:0]};
					endcase
				end
				default: utf8_byte = cp[7:0];
			endcase
		end
	endfunction

	assign cur_any  = repl_q || c2v_q || st_q != ST_NONE;
	assign out_free = !out_valid_q || out_ready;
	assign emit     = cur_any && out_free;

	always_comb begin
		repl_n = repl_q;
		c2v_n  = c2v_q;
		st_n   = st_q;
		idx_n  = idx_q;
		byte_d = 8'h00;
		kind_d = KIND_DATA;
		if (emit) begin
			if (repl_q) begin
				byte_d = utf8_byte(CP_REPL, idx_q);
				if (idx_q == utf8_last(CP_REPL)) begin
					repl_n = 1'b0;
					idx_n  = 2'd0;
				end else begin
					idx_n = idx_q + 2'd1;
				end
			end else if (c2v_q) begin
				if (c2raw_q) begin
					byte_d = c2val_q[7:0];
					c2v_n  = 1'b0;
				end else begin
					byte_d = utf8_byte(c2val_q, idx_q);
					if (idx_q == utf8_last(c2val_q)) begin
						c2v_n = 1'b0;
						idx_n = 2'd0;
					end else begin
						idx_n = idx_q + 2'd1;
					end
				end
			end else begin
				kind_d = (st_q == ST_DONE) ? KIND_DONE : KIND_BAD;
				st_n   = ST_NONE;
			end
		end
	end

	assign rest_any = repl_n || c2v_n || st_n != ST_NONE;
	// fetch the next entry as soon as the current one runs out
	assign pop      = q_valid && !rest_any;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= 1'b0;
			c2v_q  <= 1'b0;
			st_q   <= ST_NONE;
			idx_q  <= 2'd0;
		end else if (pop) begin
			repl_q <= q_entry.repl;
			c2v_q  <= q_entry.c2_v;
			st_q   <= q_entry.st;
			idx_q  <= 2'd0;
		end else begin
			repl_q <= repl_n;
			c2v_q  <= c2v_n;
			st_q   <= st_n;
			idx_q  <= idx_n;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			c2raw_q <= q_entry.c2_raw;
			c2val_q <= q_entry.c2_val;
		end
		if (emit) begin
			byte_q <= byte_d;
			kind_q <= kind_d;
			last_q <= !rest_any;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = byte_q;
	assign out_kind  = kind_q;
	assign out_last  = last_q;

endmodule

// ===== hdl/json_string_unescape_utf8.sv =====
// JSON string unescaper to UTF-8. Feed the quoted string one byte per word on
// the slave side, opening quote first, with tlast on the final byte. Each
// input word yields zero to seven result words on the master side: decoded
// UTF-8 bytes (tuser 0), then possibly a status word, done (1) or invalid (2);
// tlast marks the final result of an input word. The front decoder takes one
// byte every cycle while its entry queue (QUEUE_DEPTH entries) has room; the
// back end sends one result word per cycle while m_tready is high, so the rate
// is one input byte per cycle as long as results average at most one byte per
// input and the output is not stalled. An input word is stored in the entry
// queue, then in the back-end entry registers, then in the output register,
// before its first result word is presented.
module json_string_unescape_utf8 import jsu_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // end_of_input
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [1:0] m_tuser,   // [1:0] kind
	output logic       m_tlast    // last_of_run
);

	logic   push, push_ready, pop, pop_valid;
	entry_t push_entry, pop_entry;

	jsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.in_eoi     (s_tlast),
		.q_ready    (push_ready),
		.push       (push),
		.push_entry (push_entry)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.pop_valid  (pop_valid)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (pop_valid),
		.q_entry   (pop_entry),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_kind  (m_tuser),
		.out_last  (m_tlast)
	);

endmodule
